[rtl/beh_pkg.sv]
// shared constants and controller/datapath interface types for the byte entropy histogram
package beh_pkg;
	localparam int BIN_W = 8;
	localparam int CNT_W = 31;
	localparam logic [CNT_W-1:0] BYTE_LIMIT = 31'd1073741824;
	localparam int LOG_W = 29;
	localparam int LOG_FRAC = 24;
	localparam int LOG_INT_W = 5;
	localparam int PROD_W = 64;
	localparam int DEN_W = 40;
	localparam int QUO_W = 21;
	localparam int ENT_W = 20;
	localparam int RAT_W = 17;
	localparam logic [ENT_W-1:0] ENTROPY_MAX = 20'd524288;
	localparam logic [RAT_W-1:0] RATIO_MAX = 17'd65536;

	typedef struct packed {
		logic accept;
		logic cnt_wr;
		logic scan_rd;
		logic scan_chk;
		logic log_start;
		logic log_sel_tot;
		logic mul;
		logic mul_sel_tot;
		logic acc;
		logic idx_inc;
		logic div_start;
		logic div_sel_ratio;
		logic ent_cap;
		logic rat_cap;
		logic out_load;
	} cmd_t;

	typedef struct packed {
		logic last;
		logic c_zero;
		logic idx_last;
		logic tot_zero;
		logic log_done;
		logic div_done;
		logic out_free;
	} sts_t;
endpackage

[rtl/beh_log.sv]
// iterative log2 unit, q.24 result, normalize then one squaring per cycle
module beh_log (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic [beh_pkg::CNT_W-1:0]  x,
	output logic                       done,
	output logic [beh_pkg::LOG_W-1:0]  lg
);
	import beh_pkg::*;

	logic                   busy_q, norm_q, done_q;
	logic [CNT_W-1:0]       y_q;
	logic [LOG_INT_W-1:0]   n_q;
	logic [LOG_FRAC-1:0]    frac_q;
	logic [LOG_INT_W-1:0]   cnt_q;
	logic [2*CNT_W-1:0]     sq;
	logic [CNT_W:0]         t;

	assign sq = {{CNT_W{1'b0}}, y_q} * {{CNT_W{1'b0}}, y_q};
	assign t = sq[2*CNT_W-1:CNT_W-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			norm_q <= 1'b0;
			done_q <= 1'b0;
			y_q <= '0;
			n_q <= '0;
			frac_q <= '0;
			cnt_q <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			norm_q <= 1'b1;
			done_q <= 1'b0;
			y_q <= x;
			n_q <= LOG_INT_W'(CNT_W - 1);
			frac_q <= '0;
			cnt_q <= '0;
		end else if (busy_q) begin
			if (norm_q) begin
				if (y_q[CNT_W-1]) begin
					norm_q <= 1'b0;
				end else begin
					y_q <= {y_q[CNT_W-2:0], 1'b0};
					n_q <= n_q - 1'b1;
				end
			end else begin
				frac_q <= {frac_q[LOG_FRAC-2:0], t[CNT_W]};
				y_q <= t[CNT_W] ? t[CNT_W:1] : t[CNT_W-1:0];
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == LOG_INT_W'(LOG_FRAC - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign done = done_q;
	assign lg = {n_q, frac_q};
endmodule

[rtl/beh_div.sv]
// restoring divider, one quotient bit per cycle
module beh_div (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [beh_pkg::PROD_W-1:0]  dividend,
	input  logic [beh_pkg::DEN_W-1:0]   divisor,
	output logic                        done,
	output logic [beh_pkg::QUO_W-1:0]   quo
);
	import beh_pkg::*;

	logic                busy_q, done_q;
	logic [PROD_W-1:0]   rem_q, den_q;
	logic [QUO_W-1:0]    q_q;
	logic [4:0]          cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			rem_q <= '0;
			den_q <= '0;
			q_q <= '0;
			cnt_q <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			rem_q <= dividend;
			den_q <= PROD_W'(divisor) << (QUO_W - 1);
			q_q <= '0;
			cnt_q <= '0;
		end else if (busy_q) begin
			if (rem_q >= den_q) begin
				rem_q <= rem_q - den_q;
				q_q <= {q_q[QUO_W-2:0], 1'b1};
			end else begin
				q_q <= {q_q[QUO_W-2:0], 1'b0};
			end
			den_q <= den_q >> 1;
			cnt_q <= cnt_q + 1'b1;
			if (cnt_q == 5'(QUO_W - 1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	assign done = done_q;
	assign quo = q_q;
endmodule

[rtl/beh_ctrl.sv]
// controller state machine for counting, bin scan and result
module beh_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            src_valid,
	output logic            src_stall,
	input  beh_pkg::sts_t   sts,
	output beh_pkg::cmd_t   cmd
);
	import beh_pkg::*;

	typedef enum logic [13:0] {
		S_IDLE   = 14'b00000000000001,
		S_CNT    = 14'b00000000000010,
		S_SCAN   = 14'b00000000000100,
		S_CHK    = 14'b00000000001000,
		S_LOG    = 14'b00000000010000,
		S_MUL    = 14'b00000000100000,
		S_ACC    = 14'b00000001000000,
		S_NEXT   = 14'b00000010000000,
		S_TLOG   = 14'b00000100000000,
		S_TMUL   = 14'b00001000000000,
		S_ESTART = 14'b00010000000000,
		S_EWAIT  = 14'b00100000000000,
		S_RWAIT  = 14'b01000000000000,
		S_OUT    = 14'b10000000000000
	} state_t;

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign src_stall = (state_q != S_IDLE);

	always_comb begin
		state_d = state_q;
		cmd = '0;
		case (state_q)
			S_IDLE: begin
				if (src_valid) begin
					cmd.accept = 1'b1;
					state_d = S_CNT;
				end
			end
			S_CNT: begin
				cmd.cnt_wr = 1'b1;
				state_d = sts.last ? S_SCAN : S_IDLE;
			end
			S_SCAN: begin
				if (sts.tot_zero) begin
					state_d = S_OUT;
				end else begin
					cmd.scan_rd = 1'b1;
					state_d = S_CHK;
				end
			end
			S_CHK: begin
				cmd.scan_chk = 1'b1;
				if (sts.c_zero) begin
					state_d = S_NEXT;
				end else begin
					cmd.log_start = 1'b1;
					state_d = S_LOG;
				end
			end
			S_LOG: begin
				if (sts.log_done) begin
					state_d = S_MUL;
				end
			end
			S_MUL: begin
				cmd.mul = 1'b1;
				state_d = S_ACC;
			end
			S_ACC: begin
				cmd.acc = 1'b1;
				state_d = S_NEXT;
			end
			S_NEXT: begin
				if (sts.idx_last) begin
					cmd.log_start = 1'b1;
					cmd.log_sel_tot = 1'b1;
					state_d = S_TLOG;
				end else begin
					cmd.idx_inc = 1'b1;
					state_d = S_SCAN;
				end
			end
			S_TLOG: begin
				if (sts.log_done) begin
					state_d = S_TMUL;
				end
			end
			S_TMUL: begin
				cmd.mul = 1'b1;
				cmd.mul_sel_tot = 1'b1;
				state_d = S_ESTART;
			end
			S_ESTART: begin
				cmd.div_start = 1'b1;
				state_d = S_EWAIT;
			end
			S_EWAIT: begin
				if (sts.div_done) begin
					cmd.ent_cap = 1'b1;
					cmd.div_start = 1'b1;
					cmd.div_sel_ratio = 1'b1;
					state_d = S_RWAIT;
				end
			end
			S_RWAIT: begin
				if (sts.div_done) begin
					cmd.rat_cap = 1'b1;
					state_d = S_OUT;
				end
			end
			S_OUT: begin
				if (sts.out_free) begin
					cmd.out_load = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end
endmodule

[rtl/beh_dp.sv]
// datapath: bin memory, totals, log and divide units, result register
module beh_dp (
	input  logic                         clk,
	input  logic                         arst_n,
	input  beh_pkg::cmd_t                cmd,
	output beh_pkg::sts_t                sts,
	input  logic [beh_pkg::BIN_W-1:0]    data_byte,
	input  logic                         byte_valid,
	input  logic                         last,
	output logic                         res_valid,
	input  logic                         res_stall,
	output logic [beh_pkg::ENT_W-1:0]    entropy_q16,
	output logic [beh_pkg::CNT_W-1:0]    num_bytes,
	output logic [beh_pkg::RAT_W-1:0]    max_ratio_q8
);
	import beh_pkg::*;

	localparam int NBINS = 1 << BIN_W;

	logic [CNT_W-1:0]   mem_q [NBINS];
	logic [NBINS-1:0]   vld_q;
	logic [CNT_W-1:0]   rdata_q;
	logic               vbit_q;
	logic [BIN_W-1:0]   rd_addr;
	logic               rd_en;
	logic [CNT_W-1:0]   cur_c;

	logic [BIN_W-1:0]   byte_q, idx_q;
	logic               inc_q, last_q;
	logic [CNT_W-1:0]   total_q, c_q, mx_q;
	logic [PROD_W-1:0]  s_q, prod_q;
	logic [ENT_W-1:0]   ent_q, ent_o_q;
	logic [RAT_W-1:0]   rat_q, rat_o_q;
	logic [CNT_W-1:0]   cnt_o_q;
	logic               out_valid_q;

	logic               log_done;
	logic [LOG_W-1:0]   lg;
	logic [CNT_W-1:0]   log_x, mul_a;
	logic               div_done;
	logic [QUO_W-1:0]   quo;
	logic [PROD_W-1:0]  n_diff, dividend;
	logic [DEN_W-1:0]   divisor;
	logic               out_free;

	assign cur_c = vbit_q ? rdata_q : '0;
	assign rd_addr = cmd.accept ? data_byte : idx_q;
	assign rd_en = cmd.accept | cmd.scan_rd;

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rdata_q <= mem_q[rd_addr];
		end
		if (cmd.cnt_wr && inc_q) begin
			mem_q[byte_q] <= cur_c + 1'b1;
		end
	end

	assign log_x = cmd.log_sel_tot ? total_q : cur_c;
	assign mul_a = cmd.mul_sel_tot ? total_q : c_q;
	assign n_diff = (prod_q > s_q) ? (prod_q - s_q) : '0;
	assign dividend = cmd.div_sel_ratio
		? ((PROD_W'(mx_q) << 16) + PROD_W'(total_q >> 1))
		: (n_diff + (PROD_W'(total_q) << 7));
	assign divisor = cmd.div_sel_ratio ? DEN_W'(total_q) : (DEN_W'(total_q) << 8);
	assign out_free = !out_valid_q || !res_stall;

	beh_log u_log (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.log_start),
		.x      (log_x),
		.done   (log_done),
		.lg     (lg)
	);

	beh_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (dividend),
		.divisor  (divisor),
		.done     (div_done),
		.quo      (quo)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
			vbit_q <= 1'b0;
			byte_q <= '0;
			idx_q <= '0;
			inc_q <= 1'b0;
			last_q <= 1'b0;
			total_q <= '0;
			c_q <= '0;
			mx_q <= '0;
			s_q <= '0;
			prod_q <= '0;
			ent_q <= '0;
			rat_q <= '0;
			ent_o_q <= '0;
			rat_o_q <= '0;
			cnt_o_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (rd_en) begin
				vbit_q <= vld_q[rd_addr];
			end
			if (cmd.accept) begin
				byte_q <= data_byte;
				inc_q <= byte_valid && (total_q < BYTE_LIMIT);
				last_q <= last;
			end
			if (cmd.cnt_wr && inc_q) begin
				vld_q[byte_q] <= 1'b1;
				total_q <= total_q + 1'b1;
			end
			if (cmd.scan_chk) begin
				c_q <= cur_c;
				if (cur_c > mx_q) begin
					mx_q <= cur_c;
				end
			end
			if (cmd.mul) begin
				prod_q <= PROD_W'(mul_a) * PROD_W'(lg);
			end
			if (cmd.acc) begin
				s_q <= s_q + prod_q;
			end
			if (cmd.idx_inc) begin
				idx_q <= idx_q + 1'b1;
			end
			if (cmd.ent_cap) begin
				ent_q <= (quo > QUO_W'(ENTROPY_MAX)) ? ENTROPY_MAX : quo[ENT_W-1:0];
			end
			if (cmd.rat_cap) begin
				rat_q <= (quo > QUO_W'(RATIO_MAX)) ? RATIO_MAX : quo[RAT_W-1:0];
			end
			if (cmd.out_load) begin
				ent_o_q <= (total_q == '0) ? '0 : ent_q;
				rat_o_q <= (total_q == '0) ? '0 : rat_q;
				cnt_o_q <= total_q;
				out_valid_q <= 1'b1;
				vld_q <= '0;
				total_q <= '0;
				idx_q <= '0;
				s_q <= '0;
				mx_q <= '0;
			end else if (!res_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		sts.last = last_q;
		sts.c_zero = (cur_c == '0);
		sts.idx_last = (idx_q == {BIN_W{1'b1}});
		sts.tot_zero = (total_q == '0);
		sts.log_done = log_done;
		sts.div_done = div_done;
		sts.out_free = out_free;
	end

	assign res_valid = out_valid_q;
	assign entropy_q16 = ent_o_q;
	assign num_bytes = cnt_o_q;
	assign max_ratio_q8 = rat_o_q;
endmodule

[rtl/byte_entropy_histogram.sv]
// top level: byte histogram with shannon entropy and peak ratio result
// an item takes a bin read, then a bin write of the incremented count
// a last item with bytes scans all bins: each bin is read and checked, and a used bin also gets
// its log (normalize plus 24 squarings); then come the total log and both divides
// the result sits in an output register; the next item is taken while it waits
// reset clears all bin valid bits and the total at once; no clearing pass is needed
module byte_entropy_histogram (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         src_valid,
	output logic                         src_stall,
	input  logic [beh_pkg::BIN_W-1:0]    data_byte,
	input  logic                         byte_valid,
	input  logic                         last,
	output logic                         res_valid,
	input  logic                         res_stall,
	output logic [beh_pkg::ENT_W-1:0]    entropy_q16,
	output logic [beh_pkg::CNT_W-1:0]    num_bytes,
	output logic [beh_pkg::RAT_W-1:0]    max_ratio_q8
);
	import beh_pkg::*;

	cmd_t cmd;
	sts_t sts;

	beh_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.src_valid (src_valid),
		.src_stall (src_stall),
		.sts       (sts),
		.cmd       (cmd)
	);

	beh_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.sts          (sts),
		.data_byte    (data_byte),
		.byte_valid   (byte_valid),
		.last         (last),
		.res_valid    (res_valid),
		.res_stall    (res_stall),
		.entropy_q16  (entropy_q16),
		.num_bytes    (num_bytes),
		.max_ratio_q8 (max_ratio_q8)
	);
endmodule
